FILE: rtl/sek_pkg.sv
// ----------------------------------------------------------------------------
// sek_pkg
// Shared types and constants for the squared-exponential kernel core.
// ----------------------------------------------------------------------------
package sek_pkg;

  // coordinate width, signed Q4.12
  localparam int COORD_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LEN_SQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_VAR = 1'd1;

  localparam logic [23:0] INV_LEN_SQ_RST = 24'd65536;
  localparam logic [31:0] SIGNAL_VAR_RST = 32'd65536;

  // fixed-point constants
  localparam logic [39:0] ACC_MAX        = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] HALF_LOG2E_Q16 = 32'd47274;
  localparam logic [31:0] LN2_Q16        = 32'd45426;
  localparam logic [31:0] RECIP3_Q33     = 32'hAAAA_AAAB;
  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_coord;
    logic signed [COORD_W-1:0] b_coord;
    logic                      last_coord;
  } sek_in_t;

  typedef struct packed {
    logic [31:0] kernel_value;
    logic [39:0] grad_log_lengthscale;
    logic [32:0] grad_log_variance;
    logic        saturated;
  } sek_out_t;

endpackage

FILE: rtl/se_kernel_with_gradients_core.sv
// ----------------------------------------------------------------------------
// se_kernel_with_gradients_core
// Squared-exponential kernel entry with log-lengthscale and log-variance
// gradients, fed one coordinate pair per transfer.
// ----------------------------------------------------------------------------
// Each coordinate transfer goes through accept, square and accumulate; the
// square uses one shared 32x32 multiplier. The transfer marked last then
// runs a 22-step sequence on that same multiplier (distance scaling, exp2
// split, Horner polynomial, variance scaling, gradient product), and the
// next coordinate is taken once the sequencer is back in idle, which it
// enters as the result is loaded. in_stall is high while a coordinate is in
// work, and a result waits in the output register until taken; the sequence
// holds at its final step while that register is full and stalled.
module se_kernel_with_gradients_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sek_pkg::sek_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sek_pkg::sek_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [sek_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [sek_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sek_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_ACC,
    S_R0, S_R1, S_R2,
    S_Y0, S_Y1, S_Y2,
    S_V, S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7,
    S_E0, S_E1, S_K0, S_K1,
    S_G0, S_G1, S_G2
  } state_t;

  state_t              state_r;
  logic [23:0]         inv_len_sq_r;
  logic [31:0]         signal_var_r;
  logic [COORD_W-1:0]  mag_r;
  logic                last_r;
  logic [39:0]         dist_r;
  logic                clip_r;
  logic [43:0]         lo_r;
  logic [39:0]         rr_r;
  logic [23:0]         n_r;
  logic [15:0]         f_r;
  logic [28:0]         v_r;
  logic [30:0]         h_r;
  logic [30:0]         e_r;
  logic [31:0]         k_r;
  logic                out_valid_r;
  sek_out_t            out_r;

  logic                mul_en;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         prod;

  logic                in_xfer;
  logic                out_free;
  logic                out_load;
  logic [COORD_W:0]    diff;
  logic [COORD_W-1:0]  mag_nxt;
  logic [64:0]         acc_sum;
  logic [64:0]         r_sum;
  logic [63:0]         y_sum;
  logic [63:0]         k_shift;
  logic [5:0]          k_amt;
  logic [56:0]         gl_sum;
  logic                gl_sat;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_G2) && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_len_sq_r <= INV_LEN_SQ_RST;
      signal_var_r <= SIGNAL_VAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INV_LEN_SQ: inv_len_sq_r <= cfg_wdata[23:0];
        REG_SIGNAL_VAR: signal_var_r <= cfg_wdata[31:0];
        default:        ;
      endcase
    end
  end

  // coordinate difference magnitude
  assign diff    = {in_data.a_coord[COORD_W-1], in_data.a_coord}
                 - {in_data.b_coord[COORD_W-1], in_data.b_coord};
  assign mag_nxt = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

  // shared multiplier
  sek_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_SQ: begin mul_a = 32'(mag_r);          mul_b = 32'(mag_r);          end
      S_R0: begin mul_a = 32'(dist_r[19:0]);   mul_b = 32'(inv_len_sq_r);   end
      S_R1: begin mul_a = 32'(dist_r[39:20]);  mul_b = 32'(inv_len_sq_r);   end
      S_Y0: begin mul_a = 32'(rr_r[19:0]);     mul_b = HALF_LOG2E_Q16;      end
      S_Y1: begin mul_a = 32'(rr_r[39:20]);    mul_b = HALF_LOG2E_Q16;      end
      S_V:  begin mul_a = 32'(f_r);            mul_b = LN2_Q16;             end
      S_H1, S_H4, S_H6: begin
        mul_a = 32'(v_r);
        mul_b = 32'(h_r);
      end
      S_H2: begin mul_a = prod[61:30];         mul_b = RECIP3_Q33;          end
      S_E0: begin mul_a = 32'(h_r);            mul_b = 32'(h_r);            end
      S_K0: begin mul_a = signal_var_r;        mul_b = 32'(e_r);            end
      S_G0: begin mul_a = k_r;                 mul_b = 32'(rr_r[19:0]);     end
      S_G1: begin mul_a = k_r;                 mul_b = 32'(rr_r[39:20]);    end
      default: mul_en = 1'b0;
    endcase
  end

  // datapath post-processing
  assign acc_sum = {25'd0, dist_r} + {1'b0, prod};
  assign r_sum   = {1'b0, prod[43:0], 20'd0} + {21'd0, lo_r};
  assign y_sum   = {prod[43:0], 20'd0} + {20'd0, lo_r};
  assign k_amt   = 6'd30 + n_r[5:0];
  assign k_shift = prod >> k_amt;
  assign gl_sum  = {1'b0, prod[51:0], 4'd0} + {21'd0, lo_r[35:0]};
  assign gl_sat  = (gl_sum[56:40] != '0);

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dist_r      <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            mag_r   <= mag_nxt;
            last_r  <= in_data.last_coord;
            state_r <= S_SQ;
          end
        end
        S_SQ: state_r <= S_ACC;
        S_ACC: begin
          // saturating accumulate of the squared difference
          if (acc_sum > {25'd0, ACC_MAX}) begin
            dist_r <= ACC_MAX;
            clip_r <= 1'b1;
          end else begin
            dist_r <= acc_sum[39:0];
          end
          state_r <= last_r ? S_R0 : S_IDLE;
        end
        S_R0: state_r <= S_R1;
        S_R1: begin
          lo_r    <= prod[43:0];
          state_r <= S_R2;
        end
        S_R2: begin
          rr_r    <= r_sum[63:24];
          state_r <= S_Y0;
        end
        S_Y0: state_r <= S_Y1;
        S_Y1: begin
          lo_r    <= prod[43:0];
          state_r <= S_Y2;
        end
        S_Y2: begin
          // integer and fraction of r*log2(e)/2
          n_r     <= y_sum[55:32];
          f_r     <= y_sum[31:16];
          state_r <= S_V;
        end
        S_V: state_r <= S_H0;
        S_H0: begin
          v_r     <= prod[31:3];
          h_r     <= ONE_Q30 - 31'(prod[31:5]);
          state_r <= S_H1;
        end
        S_H1: state_r <= S_H2;
        S_H2: state_r <= S_H3;
        S_H3: begin
          // divide by three through the reciprocal product
          h_r     <= ONE_Q30 - prod[63:33];
          state_r <= S_H4;
        end
        S_H4: state_r <= S_H5;
        S_H5: begin
          h_r     <= ONE_Q30 - prod[61:31];
          state_r <= S_H6;
        end
        S_H6: state_r <= S_H7;
        S_H7: begin
          h_r     <= ONE_Q30 - prod[60:30];
          state_r <= S_E0;
        end
        S_E0: state_r <= S_E1;
        S_E1: begin
          e_r     <= prod[60:30];
          state_r <= S_K0;
        end
        S_K0: state_r <= S_K1;
        S_K1: begin
          // apply the 2^-n part, underflow to zero
          k_r     <= (n_r < 24'd34) ? k_shift[31:0] : 32'd0;
          state_r <= S_G0;
        end
        S_G0: state_r <= S_G1;
        S_G1: begin
          lo_r    <= 44'(prod[51:16]);
          state_r <= S_G2;
        end
        S_G2: begin
          if (out_free) begin
            out_r.kernel_value         <= k_r;
            out_r.grad_log_lengthscale <= gl_sat ? ACC_MAX : gl_sum[39:0];
            out_r.grad_log_variance    <= {k_r, 1'b0};
            out_r.saturated            <= clip_r || gl_sat;
            dist_r                     <= '0;
            clip_r                     <= 1'b0;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a new result only comes out of the final step
  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_G2))
    else $error("result raised outside the final step");

  // variance gradient is always twice the kernel value
  a_grad_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.grad_log_variance == {out_r.kernel_value, 1'b0}))
    else $error("variance gradient mismatch");

  // an accepted coordinate always goes to the squaring step
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_SQ))
    else $error("accepted coordinate not squared");

endmodule

FILE: rtl/sek_mul.sv
// ----------------------------------------------------------------------------
// sek_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module sek_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod_r
);

  // product register, holds when not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule
